// ===== rtl/avt_pkg.sv =====
// Shared types and constants for the affine vector transform.
package avt_pkg;

  localparam int unsigned NumRegs   = 6;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned AddrW     = 6;
  localparam int unsigned DataW     = 64;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned FracW     = 16;
  localparam int unsigned VecW      = CoordW + 1;
  localparam int unsigned ProdW     = VecW + CoordW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned ShiftW    = SumW - FracW;

  typedef enum logic [1:0] {
    ACT_POINT     = 2'd0,
    ACT_DIR       = 2'd1,
    ACT_INV_POINT = 2'd2,
    ACT_INV_DIR   = 2'd3
  } action_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_ROW_X_FIRST  = 3'd0,
    REG_ROW_X_SECOND = 3'd1,
    REG_ROW_Y_FIRST  = 3'd2,
    REG_ROW_Y_SECOND = 3'd3,
    REG_ROW_Z_FIRST  = 3'd4,
    REG_ROW_Z_SECOND = 3'd5
  } reg_idx_e;

  localparam logic [DataW-1:0] RstRowXFirst  = 64'h0000_0000_0001_0000;
  localparam logic [DataW-1:0] RstRowXSecond = 64'h0;
  localparam logic [DataW-1:0] RstRowYFirst  = 64'h0001_0000_0000_0000;
  localparam logic [DataW-1:0] RstRowYSecond = 64'h0;
  localparam logic [DataW-1:0] RstRowZFirst  = 64'h0;
  localparam logic [DataW-1:0] RstRowZSecond = 64'h0000_0000_0001_0000;

  typedef struct packed {
    logic [2:0][2:0][CoordW-1:0] coef;   // [row][col]
    logic [2:0][CoordW-1:0]      trans;
  } xform_t;

  typedef struct packed {
    logic valid;
    logic add_trans;
  } stg_ctrl_t;

  typedef logic [2:0][2:0][ProdW-1:0] prod_mat_t;

endpackage

// ===== rtl/avt_regs.sv =====
// APB configuration registers holding the linear part and translation.
module avt_regs
  import avt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output xform_t           xform_o
);

  logic [NumRegs-1:0][DataW-1:0] rows_q;
  logic [RegIdxW-1:0]            idx;
  logic                          wr_en;

  assign idx    = paddr[AddrW-1:AddrW-RegIdxW];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[REG_ROW_X_FIRST]  <= RstRowXFirst;
      rows_q[REG_ROW_X_SECOND] <= RstRowXSecond;
      rows_q[REG_ROW_Y_FIRST]  <= RstRowYFirst;
      rows_q[REG_ROW_Y_SECOND] <= RstRowYSecond;
      rows_q[REG_ROW_Z_FIRST]  <= RstRowZFirst;
      rows_q[REG_ROW_Z_SECOND] <= RstRowZSecond;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_X_FIRST:  rows_q[REG_ROW_X_FIRST]  <= pwdata;
        REG_ROW_X_SECOND: rows_q[REG_ROW_X_SECOND] <= pwdata;
        REG_ROW_Y_FIRST:  rows_q[REG_ROW_Y_FIRST]  <= pwdata;
        REG_ROW_Y_SECOND: rows_q[REG_ROW_Y_SECOND] <= pwdata;
        REG_ROW_Z_FIRST:  rows_q[REG_ROW_Z_FIRST]  <= pwdata;
        REG_ROW_Z_SECOND: rows_q[REG_ROW_Z_SECOND] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW_X_FIRST:  prdata = rows_q[REG_ROW_X_FIRST];
      REG_ROW_X_SECOND: prdata = rows_q[REG_ROW_X_SECOND];
      REG_ROW_Y_FIRST:  prdata = rows_q[REG_ROW_Y_FIRST];
      REG_ROW_Y_SECOND: prdata = rows_q[REG_ROW_Y_SECOND];
      REG_ROW_Z_FIRST:  prdata = rows_q[REG_ROW_Z_FIRST];
      REG_ROW_Z_SECOND: prdata = rows_q[REG_ROW_Z_SECOND];
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      xform_o.coef[r][0] = rows_q[2*r][CoordW-1:0];
      xform_o.coef[r][1] = rows_q[2*r][DataW-1:CoordW];
      xform_o.coef[r][2] = rows_q[2*r+1][CoordW-1:0];
      xform_o.trans[r]   = rows_q[2*r+1][DataW-1:CoordW];
    end
  end

endmodule

// ===== rtl/avt_mul.sv =====
// Input register and product stage: offset, operand select, nine products.
module avt_mul
  import avt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        action_i,
  input  logic [CoordW-1:0] in_x_i,
  input  logic [CoordW-1:0] in_y_i,
  input  logic [CoordW-1:0] in_z_i,
  input  xform_t            xform_i,
  output stg_ctrl_t         ctrl_o,
  output prod_mat_t         prod_o
);

  logic [2:0][CoordW-1:0]   vin;
  logic [2:0][VecW-1:0]     vec_d, vec_q;
  stg_ctrl_t                ctrl_d;
  logic                     inv_d, inv_q;
  logic                     valid_q, add_q;
  logic                     prod_valid_q, prod_add_q;
  prod_mat_t                prod_d, prod_q;
  logic signed [VecW-1:0]   op_v;
  logic signed [CoordW-1:0] op_c;
  logic signed [ProdW-1:0]  prod_s;

  assign vin = {in_z_i, in_y_i, in_x_i};

  // stage A: register the vector, subtracting the translation for inverse point
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (action_e'(action_i) == ACT_INV_POINT) begin
        vec_d[c] = {vin[c][CoordW-1], vin[c]}
                 - {xform_i.trans[c][CoordW-1], xform_i.trans[c]};
      end else begin
        vec_d[c] = {vin[c][CoordW-1], vin[c]};
      end
    end
    inv_d            = action_i[1];
    ctrl_d.valid     = accept_i;
    ctrl_d.add_trans = (action_e'(action_i) == ACT_POINT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
    inv_q <= inv_d;
    add_q <= ctrl_d.add_trans;
  end

  // stage B: products, transposed coefficients for inverse modes
  always_comb begin
    op_v   = '0;
    op_c   = '0;
    prod_s = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        op_v         = vec_q[c];
        op_c         = inv_q ? xform_i.coef[c][r] : xform_i.coef[r][c];
        prod_s       = op_v * op_c;
        prod_d[r][c] = prod_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    prod_add_q <= add_q;
  end

  assign ctrl_o = {prod_valid_q, prod_add_q};
  assign prod_o = prod_q;

endmodule

// ===== rtl/avt_sat.sv =====
// Row sums, translation add, floor shift and saturation into result register.
module avt_sat
  import avt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stg_ctrl_t              ctrl_i,
  input  prod_mat_t              prod_i,
  input  logic [2:0][CoordW-1:0] trans_i,
  output logic                   valid_o,
  output logic [2:0][CoordW-1:0] out_o,
  output logic                   overflow_o
);

  logic [2:0][SumW-1:0]   sum;
  logic [2:0][ShiftW-1:0] shr;
  logic [2:0][CoordW-1:0] res_d, res_q;
  logic [2:0]             sat;
  logic                   valid_q, ovf_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = {{2{prod_i[r][0][ProdW-1]}}, prod_i[r][0]}
             + {{2{prod_i[r][1][ProdW-1]}}, prod_i[r][1]}
             + {{2{prod_i[r][2][ProdW-1]}}, prod_i[r][2]};
      if (ctrl_i.add_trans) begin
        sum[r] = sum[r]
               + {{(SumW-CoordW-FracW){trans_i[r][CoordW-1]}}, trans_i[r], {FracW{1'b0}}};
      end
      shr[r] = sum[r][SumW-1:FracW];
      sat[r] = (shr[r][ShiftW-1:CoordW-1] != {(ShiftW-CoordW+1){1'b0}})
            && (shr[r][ShiftW-1:CoordW-1] != {(ShiftW-CoordW+1){1'b1}});
      if (!sat[r]) begin
        res_d[r] = shr[r][CoordW-1:0];
      end else if (shr[r][ShiftW-1]) begin
        res_d[r] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        res_d[r] = {1'b0, {(CoordW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ovf_q <= |sat;
  end

  assign valid_o    = valid_q;
  assign out_o      = res_q;
  assign overflow_o = ovf_q;

endmodule

// ===== rtl/affine_vector_transform.sv =====
// Top level of the affine 3x4 vector transform with APB configuration.
// Throughput: one item per cycle; busy stays low, the three stages are
//   input register, product register, result register.
// Results show on valid_o for one cycle; the receiver cannot stall.
// Reset clears the pipeline valids and loads the identity transform.
module affine_vector_transform
  import avt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action_i,
  input  logic signed [CoordW-1:0] in_x_i,
  input  logic signed [CoordW-1:0] in_y_i,
  input  logic signed [CoordW-1:0] in_z_i,
  output logic                     valid_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic signed [CoordW-1:0] out_z_o,
  output logic                     overflow_o
);

  xform_t                 xform;
  stg_ctrl_t              prod_ctrl;
  prod_mat_t              prod;
  logic [2:0][CoordW-1:0] res;

  assign busy = 1'b0;

  avt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .xform_o (xform)
  );

  avt_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start & ~busy),
    .action_i (action_i),
    .in_x_i   (in_x_i),
    .in_y_i   (in_y_i),
    .in_z_i   (in_z_i),
    .xform_i  (xform),
    .ctrl_o   (prod_ctrl),
    .prod_o   (prod)
  );

  avt_sat u_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (prod_ctrl),
    .prod_i     (prod),
    .trans_i    (xform.trans),
    .valid_o    (valid_o),
    .out_o      (res),
    .overflow_o (overflow_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];

endmodule
